// ===== hdl/rom_bank_lru_cache_assert.svh =====
// Assertion macros for the ROM bank LRU cache.
`ifndef ROM_BANK_LRU_CACHE_ASSERT_SVH
`define ROM_BANK_LRU_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RBLC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rblc assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RBLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rblc assertion failed");

`endif

// ===== hdl/rblc_pkg.sv =====
// Shared types and constants for the ROM bank LRU cache.
`default_nettype none
package rblc_pkg;

  localparam int unsigned SlotsDef     = 7;
  localparam int unsigned StampBitsDef = 32;
  localparam int unsigned BankBits     = 8;
  localparam int unsigned SlotOutBits  = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } rblc_state_e;

  // write strobes into the slot store
  typedef struct packed {
    logic wr_en;
    logic tag_en;
  } rblc_wr_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic tag_eq;
    logic stamp_lt;
  } rblc_cmp_t;

endpackage
`default_nettype wire

// ===== hdl/rblc_cmp.sv =====
// Shared compare unit: tag match and stamp ordering for one slot.
`default_nettype none
module rblc_cmp import rblc_pkg::*; #(
  parameter int unsigned STAMP_BITS = StampBitsDef
) (
  input  logic [BankBits-1:0]   tag_i,
  input  logic [BankBits-1:0]   bank_i,
  input  logic [STAMP_BITS-1:0] stamp_i,
  input  logic [STAMP_BITS-1:0] best_i,
  output rblc_cmp_t             cmp_o
);

  assign cmp_o.tag_eq   = (tag_i == bank_i);
  assign cmp_o.stamp_lt = (stamp_i < best_i);

endmodule
`default_nettype wire

// ===== hdl/rblc_slots.sv =====
// Slot store: tag and stamp per slot, one read and one write port.
`default_nettype none
module rblc_slots import rblc_pkg::*; #(
  parameter int unsigned SLOTS      = SlotsDef,
  parameter int unsigned STAMP_BITS = StampBitsDef,
  localparam int unsigned IdxBits   = $clog2(SLOTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IdxBits-1:0]    rd_idx_i,
  output logic [BankBits-1:0]   rd_tag_o,
  output logic [STAMP_BITS-1:0] rd_stamp_o,
  input  rblc_wr_t              wr_i,
  input  logic [IdxBits-1:0]    wr_idx_i,
  input  logic [BankBits-1:0]   wr_tag_i,
  input  logic [STAMP_BITS-1:0] wr_stamp_i
);

  logic [BankBits-1:0]   tag_q   [SLOTS];
  logic [STAMP_BITS-1:0] stamp_q [SLOTS];

  // slot i resets to bank i+1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_q[i]   <= BankBits'(i + 1);
        stamp_q[i] <= '0;
      end
    end else if (wr_i.wr_en) begin
      stamp_q[wr_idx_i] <= wr_stamp_i;
      if (wr_i.tag_en) begin
        tag_q[wr_idx_i] <= wr_tag_i;
      end
    end
  end

  assign rd_tag_o   = tag_q[rd_idx_i];
  assign rd_stamp_o = stamp_q[rd_idx_i];

endmodule
`default_nettype wire

// ===== hdl/rom_bank_lru_cache.sv =====
// Top level of the ROM bank LRU cache: sequencer, use counter and result register.
`default_nettype none
// Usage
//   A bank select write is one transaction: drive bank_select_i and raise
//   start_i; it is taken at a rising edge where busy_o is low. Bank 0 is
//   treated as bank 1.
//   The result (selected_bank_o, changed_o, hit_o, slot_o, load_request_o)
//   is shown for exactly one cycle with valid_o high; the receiver must take
//   it then, there is no back-pressure.
// Flow
//   Same bank as the one mapped: result in the cycle after acceptance, busy_o
//   stays low, so a new transaction may follow at once.
//   Different bank: one compare per slot through the shared compare unit,
//   stopping at the first tag match, then the commit state; busy_o is high
//   through the scan and commit states and low again when the result is shown.
// Reset
//   Slots hold banks 1 to SLOTS with zero stamps, use counter zero, bank 1
//   mapped to slot 0; no clearing pass, the block is ready at once.
module rom_bank_lru_cache import rblc_pkg::*; #(
  parameter int unsigned SLOTS      = SlotsDef,
  parameter int unsigned STAMP_BITS = StampBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [BankBits-1:0]    bank_select_i,
  output logic                   valid_o,
  output logic [BankBits-1:0]    selected_bank_o,
  output logic                   changed_o,
  output logic                   hit_o,
  output logic [SlotOutBits-1:0] slot_o,
  output logic                   load_request_o
);

  localparam int unsigned IdxBits = $clog2(SLOTS);
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(SLOTS - 1);

  rblc_state_e           state_q, state_d;
  logic [IdxBits-1:0]    idx_q, idx_d;        // scan pointer
  logic [IdxBits-1:0]    victim_q, victim_d;  // oldest slot so far, or the hit slot
  logic [STAMP_BITS-1:0] best_q, best_d;      // stamp of victim
  logic [BankBits-1:0]   bank_q, bank_d;
  logic                  hit_q, hit_d;
  logic [STAMP_BITS-1:0] cnt_q, cnt_d;        // use counter, wraps
  logic [BankBits-1:0]   cur_bank_q, cur_bank_d;
  logic [IdxBits-1:0]    cur_slot_q, cur_slot_d;

  // result register
  logic                   valid_q, valid_d;
  logic [BankBits-1:0]    res_bank_q, res_bank_d;
  logic                   res_chg_q, res_chg_d;
  logic                   res_hit_q, res_hit_d;
  logic [SlotOutBits-1:0] res_slot_q, res_slot_d;
  logic                   res_load_q, res_load_d;

  logic [BankBits-1:0]   bank_fix;
  logic [BankBits-1:0]   rd_tag;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic [STAMP_BITS-1:0] stamp_next;
  rblc_cmp_t             cmp;
  rblc_wr_t              wr;

  assign bank_fix   = (bank_select_i == '0) ? BankBits'(1) : bank_select_i;
  assign stamp_next = cnt_q + STAMP_BITS'(1);

  rblc_slots #(
    .SLOTS      (SLOTS),
    .STAMP_BITS (STAMP_BITS)
  ) u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_tag_o   (rd_tag),
    .rd_stamp_o (rd_stamp),
    .wr_i       (wr),
    .wr_idx_i   (victim_q),
    .wr_tag_i   (bank_q),
    .wr_stamp_i (stamp_next)
  );

  rblc_cmp #(
    .STAMP_BITS (STAMP_BITS)
  ) u_cmp (
    .tag_i   (rd_tag),
    .bank_i  (bank_q),
    .stamp_i (rd_stamp),
    .best_i  (best_q),
    .cmp_o   (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      cnt_q      <= '0;
      cur_bank_q <= BankBits'(1);
      cur_slot_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      cur_bank_q <= cur_bank_d;
      cur_slot_q <= cur_slot_d;
      valid_q    <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    victim_q   <= victim_d;
    best_q     <= best_d;
    bank_q     <= bank_d;
    hit_q      <= hit_d;
    res_bank_q <= res_bank_d;
    res_chg_q  <= res_chg_d;
    res_hit_q  <= res_hit_d;
    res_slot_q <= res_slot_d;
    res_load_q <= res_load_d;
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    victim_d   = victim_q;
    best_d     = best_q;
    bank_d     = bank_q;
    hit_d      = hit_q;
    cnt_d      = cnt_q;
    cur_bank_d = cur_bank_q;
    cur_slot_d = cur_slot_q;
    valid_d    = 1'b0;
    res_bank_d = res_bank_q;
    res_chg_d  = res_chg_q;
    res_hit_d  = res_hit_q;
    res_slot_d = res_slot_q;
    res_load_d = res_load_q;
    wr         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          bank_d = bank_fix;
          if (bank_fix == cur_bank_q) begin
            // already mapped: answer straight away, nothing moves
            valid_d    = 1'b1;
            res_bank_d = bank_fix;
            res_chg_d  = 1'b0;
            res_hit_d  = 1'b1;
            res_slot_d = SlotOutBits'(cur_slot_q);
            res_load_d = 1'b0;
          end else begin
            idx_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cmp.tag_eq) begin
          hit_d    = 1'b1;
          victim_d = idx_q;
          state_d  = ST_COMMIT;
        end else begin
          // strict less-than keeps the lowest index on a tie
          if (idx_q == '0 || cmp.stamp_lt) begin
            victim_d = idx_q;
            best_d   = rd_stamp;
          end
          if (idx_q == LastIdx) begin
            hit_d   = 1'b0;
            state_d = ST_COMMIT;
          end else begin
            idx_d = idx_q + IdxBits'(1);
          end
        end
      end
      ST_COMMIT: begin
        wr.wr_en   = 1'b1;
        wr.tag_en  = !hit_q;
        cnt_d      = stamp_next;
        cur_bank_d = bank_q;
        cur_slot_d = victim_q;
        valid_d    = 1'b1;
        res_bank_d = bank_q;
        res_chg_d  = 1'b1;
        res_hit_d  = hit_q;
        res_slot_d = SlotOutBits'(victim_q);
        res_load_d = !hit_q;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign valid_o         = valid_q;
  assign selected_bank_o = res_bank_q;
  assign changed_o       = res_chg_q;
  assign hit_o           = res_hit_q;
  assign slot_o          = res_slot_q;
  assign load_request_o  = res_load_q;

`include "rom_bank_lru_cache_assert.svh"

  // a load is only asked for on a genuine miss
  `RBLC_ASSERT_IMPL(a_load_is_miss, valid_o && load_request_o, changed_o && !hit_o)
  // an unchanged bank never touches the slots
  `RBLC_ASSERT_IMPL(a_same_no_load, valid_o && !changed_o, hit_o && !load_request_o)
  // an accepted transaction either answers next cycle or keeps the block busy
  `RBLC_ASSERT_NEXT(a_accept_progress, start_i && !busy_o, valid_o || busy_o)
  // bank zero never reaches the result
  `RBLC_ASSERT_IMPL(a_bank_nonzero, valid_o, selected_bank_o != '0)

endmodule
`default_nettype wire
